// File: hdl/per_flow_cumulative_ack_receiver_core_defines.svh
// Assertion macros for the per-flow cumulative ACK receiver.
// Included by the top level; depends on nothing else.
`ifndef PER_FLOW_CUMULATIVE_ACK_RECEIVER_CORE_DEFINES_SVH
`define PER_FLOW_CUMULATIVE_ACK_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check
`define PFCAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfcar: same-cycle check failed");
// Next-cycle implication check
`define PFCAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfcar: next-cycle check failed");
`else
`define PFCAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PFCAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/pfcar_pkg.sv
// Shared types and constants of the per-flow cumulative ACK receiver.
// No dependencies.
`default_nettype none

package pfcar_pkg;

	// Bit of pkt_flags that marks a data packet
	localparam int unsigned DATA_FLAG_BIT = 3;

	// Queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;

	// ACK kind codes
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_IN_ORDER = 2'd1,
		KIND_DUP      = 2'd2,
		KIND_AHEAD    = 2'd3
	} kind_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic        drop;
		logic        data;
		logic [7:0]  flow;
		logic [31:0] seq;
		logic [15:0] plen;
	} item_t;

	// Per-flow state word
	typedef struct packed {
		logic [31:0] expected;
		logic [31:0] packets;
		logic [31:0] acks;
		logic [63:0] bytes;
	} flow_state_t;

endpackage

`default_nettype wire

// File: hdl/pfcar_front.sv
// Front end: accepts packet headers and classifies them (drop, data).
// Depends on pfcar_pkg.
`default_nettype none

module pfcar_front #(
	parameter int unsigned FLOWS = 8
) (
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 frame_ok,
	input  wire  [15:0]         flow_id,
	input  wire  [31:0]         seq_num,
	input  wire  [15:0]         pkt_flags,
	input  wire  [15:0]         payload_len,
	input  wire                 q_full,
	output logic                q_push,
	output pfcar_pkg::item_t    q_item
);
	import pfcar_pkg::*;

	// Hold the source while the queue is full
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Classify the header
	always_comb begin
		q_item.drop = !frame_ok || ({1'b0, flow_id} >= 17'(FLOWS));
		q_item.data = pkt_flags[DATA_FLAG_BIT];
		q_item.flow = flow_id[7:0];
		q_item.seq  = seq_num;
		q_item.plen = payload_len;
	end

endmodule

`default_nettype wire

// File: hdl/pfcar_queue.sv
// Short FIFO of classified items between front and back.
// Depends on pfcar_pkg.
`default_nettype none

module pfcar_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  pfcar_pkg::item_t    push_item,
	output logic                full,
	input  wire                 pop,
	output logic                nonempty,
	output pfcar_pkg::item_t    pop_item
);
	import pfcar_pkg::*;

	item_t              slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full     = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// File: hdl/pfcar_back.sv
// Back end: per-flow state memory, read-modify-write and result register.
// Depends on pfcar_pkg.
`default_nettype none

module pfcar_back #(
	parameter int unsigned FLOWS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	input  pfcar_pkg::item_t    q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic                ack_send,
	output logic [7:0]          ack_flow,
	output logic [31:0]         ack_number,
	output logic [1:0]          ack_kind,
	output logic                dropped,
	output logic [31:0]         flow_packets,
	output logic [63:0]         flow_bytes,
	output logic [31:0]         flow_acks
);
	import pfcar_pkg::*;

	localparam int unsigned IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	state_t            state_q;
	flow_state_t       mem_q [FLOWS];
	logic [FLOWS-1:0]  active_q;

	item_t             cur_s1;
	flow_state_t       rd_s1;
	logic              act_s1;

	logic [IDX_W-1:0]  pop_idx;
	logic [IDX_W-1:0]  cur_idx;
	flow_state_t       base;
	flow_state_t       upd;
	kind_t             kind;

	assign pop_idx = q_item.flow[IDX_W-1:0];
	assign cur_idx = cur_s1.flow[IDX_W-1:0];

	// Take the next item when idle or when the result leaves this cycle
	assign q_pop = q_valid && ((state_q == S_IDLE) || ((state_q == S_OUT) && !out_stall));

	// Latch the popped item and read its flow state
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1 <= q_item;
			rd_s1  <= mem_q[pop_idx];
			act_s1 <= active_q[pop_idx];
		end
	end

	// Update the flow state; an inactive flow reads as zero
	always_comb begin
		base = act_s1 ? rd_s1 : '0;
		upd  = base;
		kind = KIND_NONE;
		if (cur_s1.data) begin
			if (cur_s1.seq == base.expected) begin
				upd.expected = cur_s1.seq + 32'd1;
				upd.packets  = base.packets + 32'd1;
				upd.bytes    = base.bytes + {48'd0, cur_s1.plen};
				kind         = KIND_IN_ORDER;
			end else if (cur_s1.seq < base.expected) begin
				kind = KIND_DUP;
			end else begin
				kind = KIND_AHEAD;
			end
			upd.acks = base.acks + 32'd1;
		end
	end

	// Write back the state of an accepted flow
	always_ff @(posedge clk) begin
		if ((state_q == S_READ) && !cur_s1.drop) mem_q[cur_idx] <= upd;
	end

	// Sequencer, activity bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= '0;
			out_valid    <= 1'b0;
			ack_send     <= 1'b0;
			ack_flow     <= '0;
			ack_number   <= '0;
			ack_kind     <= KIND_NONE;
			dropped      <= 1'b0;
			flow_packets <= '0;
			flow_bytes   <= '0;
			flow_acks    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) state_q <= S_READ;
				end
				S_READ: begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
					if (cur_s1.drop) begin
						ack_send     <= 1'b0;
						ack_flow     <= '0;
						ack_number   <= '0;
						ack_kind     <= KIND_NONE;
						dropped      <= 1'b1;
						flow_packets <= '0;
						flow_bytes   <= '0;
						flow_acks    <= '0;
					end else begin
						active_q[cur_idx] <= 1'b1;
						ack_send     <= cur_s1.data;
						ack_flow     <= cur_s1.flow;
						ack_number   <= upd.expected;
						ack_kind     <= kind;
						dropped      <= 1'b0;
						flow_packets <= upd.packets;
						flow_bytes   <= upd.bytes;
						flow_acks    <= upd.acks;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= q_pop ? S_READ : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/per_flow_cumulative_ack_receiver_core.sv
// Per-flow cumulative ACK receiver (go-back-N style).
// Accepted headers pass through the queue, then the back end reads the flow state and registers the result.
// The back end takes a new item only when idle or as its result leaves; each item passes S_READ then S_OUT.
// A 4-entry queue lets the input keep accepting while a result waits to be taken.
// Reset (arst_n low, asynchronous) empties the queue and marks every flow inactive.
`default_nettype none
`include "per_flow_cumulative_ack_receiver_core_defines.svh"

module per_flow_cumulative_ack_receiver_core #(
	parameter int unsigned FLOWS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         frame_ok,
	input  wire  [15:0] flow_id,
	input  wire  [31:0] seq_num,
	input  wire  [15:0] pkt_flags,
	input  wire  [15:0] payload_len,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        ack_send,
	output logic [7:0]  ack_flow,
	output logic [31:0] ack_number,
	output logic [1:0]  ack_kind,
	output logic        dropped,
	output logic [31:0] flow_packets,
	output logic [63:0] flow_bytes,
	output logic [31:0] flow_acks
);
	import pfcar_pkg::*;

	logic  q_full;
	logic  q_push;
	logic  q_nonempty;
	logic  q_pop;
	item_t push_item;
	item_t pop_item;

	// Classify incoming headers
	pfcar_front #(
		.FLOWS (FLOWS)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_ok    (frame_ok),
		.flow_id     (flow_id),
		.seq_num     (seq_num),
		.pkt_flags   (pkt_flags),
		.payload_len (payload_len),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	// Buffer classified items
	pfcar_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_item  (pop_item)
	);

	// Update flow state and present results
	pfcar_back #(
		.FLOWS (FLOWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_nonempty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ack_send     (ack_send),
		.ack_flow     (ack_flow),
		.ack_number   (ack_number),
		.ack_kind     (ack_kind),
		.dropped      (dropped),
		.flow_packets (flow_packets),
		.flow_bytes   (flow_bytes),
		.flow_acks    (flow_acks)
	);

	// A dropped item carries no ACK and no counters
	`PFCAR_ASSERT_IMP(a_drop_clean, clk, arst_n, out_valid && dropped, !ack_send && (ack_kind == KIND_NONE) && (flow_acks == 32'd0))
	// An ACK is sent exactly when a kind is reported
	`PFCAR_ASSERT_IMP(a_send_kind, clk, arst_n, out_valid, ack_send == (ack_kind != KIND_NONE))
	// A popped item is not yet presented in the following cycle
	`PFCAR_ASSERT_NXT(a_pop_gap, clk, arst_n, q_pop, !out_valid)

endmodule

`default_nettype wire
